[src/indexed_list_insert_remove_core_assert.svh]
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core_assert
// Assertion macros used by the indexed list datapath (ilir_dp).
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// Checked on every rising edge, switched off while reset is asserted.
`define ILIR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ILIR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ilir_pkg.sv]
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants of the indexed list block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed port widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENT_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request beat
    logic rd_pos;    // read entry at position
    logic rd_shift;  // read neighbor of shift index
    logic wr_shift;  // write read data at shift index
    logic wr_pos;    // write item value at position
    logic idx_step;  // advance shift index
    logic cnt_inc;
    logic cnt_dec;
    logic finish;    // load result register
  } ilir_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e act;
    logic    ok;        // request is legal
    logic    more;      // shift loop not yet done
    logic    out_free;  // result register can take a beat
  } ilir_sts_t;

endpackage

`default_nettype wire

[src/indexed_list_insert_remove_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Ordered list of signed words with get, set, insert and remove at a position.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries action_i, position_i and
//   item_value_i; result channel (out_valid_o/out_ready_i) returns one beat
//   per request: read_value_o, success_o, entries_now_o.
//   One request is worked on at a time. With n = entries before the request
//   and p = position: a get reads the entry at p, then registers the result;
//   a set, or a rejected request, registers the result directly. Insert moves
//   the n - p entries from p up by one, remove moves those above p down by one.
//   Each moved entry costs a memory read then a memory write; the next
//   request is accepted the cycle after the result is registered.
//   The result register lets a new request be accepted while the previous
//   result waits; if the receiver stalls, the next result waits in the
//   controller until the register frees, with in_ready_o low meanwhile.
//   Reset empties the list (count zero) at once; entry RAM is not cleared,
//   it is only ever read below the count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_core #(
  parameter int unsigned CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [ilir_pkg::ACT_W-1:0]        action_i,
  input  wire logic [ilir_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ilir_pkg::VAL_W-1:0] item_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [ilir_pkg::VAL_W-1:0]      read_value_o,
  output logic                                   success_o,
  output logic [ilir_pkg::ENT_W-1:0]             entries_now_o
);

  // controller <-> datapath
  ilir_pkg::ilir_cmd_t cmd;
  ilir_pkg::ilir_sts_t sts;

  // sequencer: accept, shift loop, result issue
  ilir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry RAM, count, shift index, result register
  ilir_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .read_value_o  (read_value_o),
    .success_o     (success_o),
    .entries_now_o (entries_now_o)
  );

endmodule

`default_nettype wire

[src/ilir_ctrl.sv]
// ----------------------------------------------------------------------------
// ilir_ctrl
// Request sequencer: accepts a beat, walks the shift loop, issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ilir_pkg::ilir_sts_t sts_i,
  output ilir_pkg::ilir_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_GET
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.ok) begin
          if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          case (sts_i.act)
            ilir_pkg::ACT_GET: begin
              cmd_o.rd_pos = 1'b1;
              state_d      = ST_GET;
            end
            ilir_pkg::ACT_SET: begin
              if (sts_i.out_free) begin
                cmd_o.wr_pos = 1'b1;
                cmd_o.finish = 1'b1;
                state_d      = ST_IDLE;
              end
            end
            ilir_pkg::ACT_INSERT: begin
              if (sts_i.more) begin
                cmd_o.rd_shift = 1'b1;
                state_d        = ST_SHIFT;
              end else if (sts_i.out_free) begin
                cmd_o.wr_pos  = 1'b1;
                cmd_o.cnt_inc = 1'b1;
                cmd_o.finish  = 1'b1;
                state_d       = ST_IDLE;
              end
            end
            default: begin
              if (sts_i.more) begin
                cmd_o.rd_shift = 1'b1;
                state_d        = ST_SHIFT;
              end else if (sts_i.out_free) begin
                cmd_o.cnt_dec = 1'b1;
                cmd_o.finish  = 1'b1;
                state_d       = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_step = 1'b1;
        state_d        = ST_EXEC;
      end
      ST_GET: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

[src/ilir_dp.sv]
// ----------------------------------------------------------------------------
// ilir_dp
// Entry memory, entry count, shift index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_remove_core_assert.svh"

module ilir_dp #(
  parameter int unsigned CAPACITY   = ilir_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [ilir_pkg::ACT_W-1:0]        action_i,
  input  wire logic [ilir_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ilir_pkg::VAL_W-1:0] item_value_i,
  input  wire ilir_pkg::ilir_cmd_t               cmd_i,
  output ilir_pkg::ilir_sts_t                    sts_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [ilir_pkg::VAL_W-1:0]      read_value_o,
  output logic                                   success_o,
  output logic [ilir_pkg::ENT_W-1:0]             entries_now_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = ilir_pkg::POS_W;
  localparam int unsigned VW   = ilir_pkg::VAL_W;
  localparam int unsigned EW   = ilir_pkg::ENT_W;
  localparam int unsigned CMPW = (CW > PW) ? CW : PW;
  localparam int unsigned DW   = DATA_WIDTH;

  logic [DW-1:0] mem [CAPACITY];

  ilir_pkg::action_e act_q;
  logic [PW-1:0]     pos_q;
  logic [DW-1:0]     val_q;
  logic              ok_q, ok_d;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     rdata_q;
  logic signed [DW-1:0] rdata_s;

  logic              out_valid_q;
  logic signed [VW-1:0] rv_q;
  logic              succ_q;
  logic [EW-1:0]     ent_q;

  logic              full;
  logic [CW-1:0]     shift_src;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DW-1:0]     wr_data;
  logic              wr_en;
  logic              more;

  // legality of an incoming request
  assign full = (cnt_q == CW'(CAPACITY));
  always_comb begin
    case (action_i)
      ilir_pkg::ACT_INSERT: ok_d = (CMPW'(position_i) <= CMPW'(cnt_q)) && !full;
      default:              ok_d = (CMPW'(position_i) <  CMPW'(cnt_q));
    endcase
  end

  // insert walks down from the count, remove walks up from the position
  always_comb begin
    if (act_q == ilir_pkg::ACT_INSERT) begin
      more      = (CMPW'(idx_q) > CMPW'(pos_q));
      shift_src = idx_q - CW'(1);
    end else begin
      more      = ((idx_q + CW'(1)) < cnt_q);
      shift_src = idx_q + CW'(1);
    end
  end

  assign rd_addr = cmd_i.rd_pos ? AW'(pos_q) : shift_src[AW-1:0];
  assign wr_en   = cmd_i.wr_shift || cmd_i.wr_pos;
  assign wr_addr = cmd_i.wr_shift ? idx_q[AW-1:0] : AW'(pos_q);
  assign wr_data = cmd_i.wr_shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_pos || cmd_i.rd_shift) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // request capture and shift index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= position_i;
      val_q <= DW'(item_value_i);
      idx_q <= (ilir_pkg::action_e'(action_i) == ilir_pkg::ACT_INSERT) ? cnt_q
                                                                        : CW'(position_i);
    end else if (cmd_i.idx_step) begin
      idx_q <= shift_src;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ilir_pkg::ACT_GET;
      ok_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        act_q <= ilir_pkg::action_e'(action_i);
        ok_q  <= ok_d;
      end
      cnt_q <= cnt_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rdata_s = rdata_q;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (act_q == ilir_pkg::ACT_GET) begin
        rv_q <= ok_q ? VW'(rdata_s) : '1;
      end else begin
        rv_q <= '0;
      end
      succ_q <= ok_q;
      ent_q  <= EW'(cnt_d);
    end
  end

  assign sts_o.act      = act_q;
  assign sts_o.ok       = ok_q;
  assign sts_o.more     = more;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rv_q;
  assign success_o     = succ_q;
  assign entries_now_o = ent_q;

  `ILIR_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || (cnt_q <= CW'(CAPACITY)), "entry count above capacity")
  `ILIR_ASSERT(a_finish_free, clk_i, rst_ni, cmd_i.finish |-> (!out_valid_q || out_ready_i), "result overwritten")
  `ILIR_ASSERT(a_shift_range, clk_i, rst_ni, cmd_i.wr_shift |-> (idx_q < CW'(CAPACITY)), "shift write out of range")
  `ILIR_ASSERT(a_cnt_on_finish, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> $past(cmd_i.finish), "count moved without a result")

endmodule

`default_nettype wire
